// ----- src/i2cm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: shared definitions
// Action codes, sequence segment kinds, byte sources, the write and read
// programs, and the result beat carried to the output stages.
// ----------------------------------------------------------------------------
package i2cm_pkg;

	// action codes of an input beat
	localparam logic [1:0] ACT_TICK  = 2'd0;
	localparam logic [1:0] ACT_WRITE = 2'd1;
	localparam logic [1:0] ACT_READ  = 2'd2;

	// configuration port
	localparam int unsigned PADDR_W = 2;
	localparam int unsigned PDATA_W = 32;
	localparam logic [PADDR_W-1:0] REG_DEVICE_ADDRESS = 2'd0;

	// last program index of each transaction kind
	localparam logic [3:0] WRITE_LAST_SEG = 4'd7;
	localparam logic [3:0] READ_LAST_SEG  = 4'd10;

	typedef enum logic [2:0] {
		SEG_START,
		SEG_BYTE,
		SEG_ACK,
		SEG_RECV,
		SEG_NACK,
		SEG_STOP
	} seg_kind_t;

	typedef enum logic [1:0] {
		SRC_ADDR_W,
		SRC_REG,
		SRC_DATA,
		SRC_ADDR_R
	} byte_src_t;

	typedef struct packed {
		seg_kind_t kind;
		byte_src_t src;
	} seg_entry_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
	} result_t;

	function automatic logic [4:0] seg_len(input seg_kind_t kind);
		logic [4:0] len;
		unique case (kind)
			SEG_START: len = 5'd4;
			SEG_BYTE:  len = 5'd24;
			SEG_ACK:   len = 5'd4;
			SEG_RECV:  len = 5'd25;
			SEG_NACK:  len = 5'd3;
			SEG_STOP:  len = 5'd3;
			default:   len = 5'd3;
		endcase
		return len;
	endfunction

	function automatic seg_entry_t prog_entry(input logic is_read, input logic [3:0] idx);
		seg_entry_t e;
		e = '{kind: SEG_STOP, src: SRC_ADDR_W};
		if (is_read) begin
			unique case (idx)
				4'd0:    e = '{kind: SEG_START, src: SRC_ADDR_W};
				4'd1:    e = '{kind: SEG_BYTE,  src: SRC_ADDR_W};
				4'd2:    e = '{kind: SEG_ACK,   src: SRC_ADDR_W};
				4'd3:    e = '{kind: SEG_BYTE,  src: SRC_REG};
				4'd4:    e = '{kind: SEG_ACK,   src: SRC_ADDR_W};
				4'd5:    e = '{kind: SEG_START, src: SRC_ADDR_W};
				4'd6:    e = '{kind: SEG_BYTE,  src: SRC_ADDR_R};
				4'd7:    e = '{kind: SEG_ACK,   src: SRC_ADDR_W};
				4'd8:    e = '{kind: SEG_RECV,  src: SRC_ADDR_W};
				4'd9:    e = '{kind: SEG_NACK,  src: SRC_ADDR_W};
				default: e = '{kind: SEG_STOP,  src: SRC_ADDR_W};
			endcase
		end else begin
			unique case (idx)
				4'd0:    e = '{kind: SEG_START, src: SRC_ADDR_W};
				4'd1:    e = '{kind: SEG_BYTE,  src: SRC_ADDR_W};
				4'd2:    e = '{kind: SEG_ACK,   src: SRC_ADDR_W};
				4'd3:    e = '{kind: SEG_BYTE,  src: SRC_REG};
				4'd4:    e = '{kind: SEG_ACK,   src: SRC_ADDR_W};
				4'd5:    e = '{kind: SEG_BYTE,  src: SRC_DATA};
				4'd6:    e = '{kind: SEG_ACK,   src: SRC_ADDR_W};
				default: e = '{kind: SEG_STOP,  src: SRC_ADDR_W};
			endcase
		end
		return e;
	endfunction

endpackage

// ----- src/i2cm_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master sequencer
// Holds the transaction state and performs at most one line operation per tick;
// gives the result beat for the beat being accepted.
// ----------------------------------------------------------------------------
module i2cm_seq import i2cm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step_en,
	input  logic [1:0] action,
	input  logic [7:0] reg_address,
	input  logic [7:0] write_data,
	input  logic       sda_in,
	input  logic [6:0] device_address,
	output result_t    result
);

	logic [3:0] seg_idx_q, seg_idx_d;
	logic [4:0] off_q, off_d;
	logic [1:0] phase_q, phase_d;
	logic [2:0] bit_q, bit_d;
	logic       is_read_q, is_read_d;
	logic       busy_q, busy_d;
	logic [7:0] held_reg_q, held_reg_d;
	logic [7:0] held_data_q, held_data_d;
	logic [7:0] rx_q, rx_d;
	logic       scl_q, scl_d;
	logic       sda_q, sda_d;
	logic       done;

	seg_entry_t seg;
	logic [7:0] tx_byte;
	logic       seg_end;
	logic       adv_phase;

	always_comb begin
		seg = prog_entry(is_read_q, seg_idx_q);
		unique case (seg.src)
			SRC_ADDR_W: tx_byte = {device_address, 1'b0};
			SRC_REG:    tx_byte = held_reg_q;
			SRC_DATA:   tx_byte = held_data_q;
			SRC_ADDR_R: tx_byte = {device_address, 1'b1};
			default:    tx_byte = held_reg_q;
		endcase
		seg_end   = (off_q == seg_len(seg.kind) - 5'd1);
		// receive phases start one step late, after the SDA release
		adv_phase = (seg.kind == SEG_BYTE) || (seg.kind == SEG_RECV && off_q != 5'd0);
	end

	always_comb begin
		seg_idx_d   = seg_idx_q;
		off_d       = off_q;
		phase_d     = phase_q;
		bit_d       = bit_q;
		is_read_d   = is_read_q;
		busy_d      = busy_q;
		held_reg_d  = held_reg_q;
		held_data_d = held_data_q;
		rx_d        = rx_q;
		scl_d       = scl_q;
		sda_d       = sda_q;
		done        = 1'b0;
		if (step_en) begin
			priority if (action == ACT_TICK) begin
				if (busy_q) begin
					unique case (seg.kind)
						SEG_START: begin
							unique case (off_q[1:0])
								2'd0:    sda_d = 1'b1;
								2'd1:    scl_d = 1'b1;
								2'd2:    sda_d = 1'b0;
								default: scl_d = 1'b0;
							endcase
						end
						SEG_BYTE: begin
							unique case (phase_q)
								2'd0:    sda_d = tx_byte[3'd7 - bit_q];
								2'd1:    scl_d = 1'b1;
								default: scl_d = 1'b0;
							endcase
						end
						SEG_ACK: begin
							unique case (off_q[1:0])
								2'd0:    sda_d = 1'b1;
								2'd1:    scl_d = 1'b1;
								2'd3:    scl_d = 1'b0;
								default: ;
							endcase
						end
						SEG_RECV: begin
							if (off_q == 5'd0) begin
								sda_d = 1'b1;
							end else begin
								unique case (phase_q)
									2'd0:    scl_d = 1'b1;
									2'd1:    rx_d[3'd7 - bit_q] = sda_in;
									default: scl_d = 1'b0;
								endcase
							end
						end
						SEG_NACK: begin
							unique case (off_q[1:0])
								2'd0:    sda_d = 1'b1;
								2'd1:    scl_d = 1'b1;
								default: scl_d = 1'b0;
							endcase
						end
						default: begin
							unique case (off_q[1:0])
								2'd0:    sda_d = 1'b0;
								2'd1:    scl_d = 1'b1;
								default: sda_d = 1'b1;
							endcase
						end
					endcase

					if (seg_end) begin
						off_d   = 5'd0;
						phase_d = 2'd0;
						bit_d   = 3'd0;
						if (seg_idx_q == (is_read_q ? READ_LAST_SEG : WRITE_LAST_SEG)) begin
							seg_idx_d = 4'd0;
							busy_d    = 1'b0;
							done      = 1'b1;
						end else begin
							seg_idx_d = seg_idx_q + 4'd1;
						end
					end else begin
						off_d = off_q + 5'd1;
						if (adv_phase) begin
							if (phase_q == 2'd2) begin
								phase_d = 2'd0;
								bit_d   = bit_q + 3'd1;
							end else begin
								phase_d = phase_q + 2'd1;
							end
						end
					end
				end
			end else if (action == ACT_WRITE || action == ACT_READ) begin
				if (!busy_q) begin
					held_reg_d = reg_address;
					if (action == ACT_WRITE) begin
						held_data_d = write_data;
					end
					is_read_d = (action == ACT_READ);
					busy_d    = 1'b1;
					seg_idx_d = 4'd0;
					off_d     = 5'd0;
					phase_d   = 2'd0;
					bit_d     = 3'd0;
				end
			end else begin
				// unused action code: drop the beat
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_idx_q   <= '0;
			off_q       <= '0;
			phase_q     <= '0;
			bit_q       <= '0;
			is_read_q   <= 1'b0;
			busy_q      <= 1'b0;
			held_reg_q  <= '0;
			held_data_q <= '0;
			rx_q        <= '0;
			scl_q       <= 1'b1;
			sda_q       <= 1'b1;
		end else begin
			seg_idx_q   <= seg_idx_d;
			off_q       <= off_d;
			phase_q     <= phase_d;
			bit_q       <= bit_d;
			is_read_q   <= is_read_d;
			busy_q      <= busy_d;
			held_reg_q  <= held_reg_d;
			held_data_q <= held_data_d;
			rx_q        <= rx_d;
			scl_q       <= scl_d;
			sda_q       <= sda_d;
		end
	end

	assign result = '{scl_level: scl_d, sda_level: sda_d, busy_res: busy_d,
		done_res: done, read_data: rx_d};

endmodule

// ----- src/i2c_master_register_access.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access
// Single-register I2C writes and reads, stepped one line operation per tick.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): each beat carries an action. A write
//   or read command latches reg_address (and write_data for a write) and
//   starts a transaction when idle; commands while busy are dropped. Each
//   tick beat then performs at most one line operation: drive SDA, drive SCL, or
//   sample sda_in. A write takes 91 ticks, a read 123 ticks.
//   Output channel (out_valid / out_stall): exactly one result beat per
//   input beat, carrying the SCL/SDA drives, busy, done and the receive byte.
//   Each result is registered into the output register, or into the skid register while the output entry is held.
//   Throughput: one beat per cycle while in_stall is low; the sequencer advances in a single pass.
//   A two-entry output queue (output register plus skid register) decouples
//   the sides: in_stall rises only when both entries hold results, i.e. in the
//   cycle after a beat is accepted while the receiver stalls a waiting result.
//   APB port: device_address lies at byte address 0; it is read live by the
//   address bytes. pready is always high.
//   Reset: both lines released, idle, all held bytes and the address zero.
// ----------------------------------------------------------------------------
module i2c_master_register_access import i2cm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [7:0]         reg_address,
	input  logic [7:0]         write_data,
	input  logic               sda_in,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               scl_level,
	output logic               sda_level,
	output logic               busy_res,
	output logic               done_res,
	output logic [7:0]         read_data
);

	logic [6:0] dev_addr_q;
	logic       cfg_wr;

	logic       in_acc;
	result_t    result;

	logic       out_valid_q;
	result_t    out_item_q;
	logic       skid_valid_q;
	result_t    skid_item_q;
	logic       out_take;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr == REG_DEVICE_ADDRESS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= '0;
		end else if (cfg_wr) begin
			dev_addr_q <= pwdata[6:0];
		end
	end

	// return the register on its address, zero elsewhere
	assign prdata = (paddr == REG_DEVICE_ADDRESS) ?
		{{(PDATA_W - 7){1'b0}}, dev_addr_q} : '0;

	// ---------------------------------------------------------- sequencer
	// the skid register is the only thing that can hold the input back
	assign in_stall = skid_valid_q;
	assign in_acc   = in_valid && !in_stall;

	i2cm_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.step_en        (in_acc),
		.action         (action),
		.reg_address    (reg_address),
		.write_data     (write_data),
		.sda_in         (sda_in),
		.device_address (dev_addr_q),
		.result         (result)
	);

	// ------------------------------------------------------- output queue
	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				// drain the skid entry as soon as the output is taken
				if (out_take) begin
					skid_valid_q <= 1'b0;
				end
			end else if (in_acc) begin
				if (out_valid_q && !out_take) begin
					skid_valid_q <= 1'b1;
				end else begin
					out_valid_q <= 1'b1;
				end
			end else if (out_take) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers: load on the same conditions, no reset needed
	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_take) begin
				out_item_q <= skid_item_q;
			end
		end else if (in_acc) begin
			if (out_valid_q && !out_take) begin
				skid_item_q <= result;
			end else begin
				out_item_q <= result;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign scl_level = out_item_q.scl_level;
	assign sda_level = out_item_q.sda_level;
	assign busy_res  = out_item_q.busy_res;
	assign done_res  = out_item_q.done_res;
	assign read_data = out_item_q.read_data;

	// --------------------------------------------------------- assertions
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held without an output entry");

	a_done_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && result.done_res) |-> !result.busy_res)
		else $error("transaction completed while still busy");

	a_stalled_to_skid: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && out_valid_q && out_stall) |=> skid_valid_q)
		else $error("beat accepted under stall was not held in the skid entry");

	a_stop_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && result.done_res) |-> (result.scl_level && result.sda_level))
		else $error("stop completed without both lines released");

endmodule

// ----- bench/i2c_master_register_access_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master register access: self-checking bench
// A short directed stimulus table opens the run: idle ticks, commands while
// busy, the reserved action, full writes at both address extremes and full
// reads at the high extreme and at address 2A. A long random stretch of
// well-formed transactions with noise, cut-short sequences and device address
// changes follows. A bus-level predictor computes every result beat. The
// sender bursts and pauses, the receiver stalls on a pattern of its own and
// once holds off long enough to back up the input.
// ----------------------------------------------------------------------------
module i2c_master_register_access_tb;
	import i2cm_pkg::*;

	localparam logic [1:0] ACT_RESERVED = 2'd3;
	localparam int WRITE_TICKS  = 91;
	localparam int READ_TICKS   = 123;
	localparam int RANDOM_BEATS = 500;
	localparam int LONG_HOLD    = 80;
	localparam int DRAIN_LIMIT  = 5000;
	localparam int DIRECTED_ROWS = 18;

	// fixed results that can be read straight off the protocol
	localparam result_t R_NONE    = '{1'b0, 1'b0, 1'b0, 1'b0, 8'h00};
	localparam result_t R_IDLE    = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00};
	localparam result_t R_CMD     = '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00};
	localparam result_t R_CMD_FF  = '{1'b1, 1'b1, 1'b1, 1'b0, 8'hFF};
	localparam result_t R_DONE    = '{1'b1, 1'b1, 1'b0, 1'b1, 8'h00};
	localparam result_t R_DONE_FF = '{1'b1, 1'b1, 1'b0, 1'b1, 8'hFF};

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] reg_address;
		logic [7:0] write_data;
		logic       sda_in;
	} bus_beat_t;

	typedef struct {
		bit      pinned;
		result_t want;
	} typed_result_t;

	typedef struct {
		bit          set_addr;
		logic [6:0]  addr;
		logic [1:0]  act;
		logic [7:0]  ra;
		logic [7:0]  wd;
		logic        sd;
		int unsigned reps;
		bit          pinned;
		result_t     want;
	} stim_row_t;

	typedef enum {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [PDATA_W-1:0] pwdata = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         action = ACT_TICK;
	logic [7:0]         reg_address = '0;
	logic [7:0]         write_data = '0;
	logic               sda_in = 1'b1;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic               scl_level;
	logic               sda_level;
	logic               busy_res;
	logic               done_res;
	logic [7:0]         read_data;

	// predictor state, mirrors the reset state of the block
	logic [6:0] dev_addr    = '0;
	logic [6:0] bus_step    = '0;
	logic       bus_is_read = 1'b0;
	logic       bus_busy    = 1'b0;
	logic [7:0] bus_reg     = '0;
	logic [7:0] bus_data    = '0;
	logic [7:0] bus_rx      = '0;
	logic       bus_scl     = 1'b1;
	logic       bus_sda     = 1'b1;

	result_t       bus_results_due [$];
	typed_result_t typed_results [$];

	int errors = 0;
	int beats_sent = 0;
	int writes_done = 0;
	int reads_done = 0;
	int addr_writes = 0;
	int input_held = 0;
	int burst_left = 0;
	int dense_left = 0;
	bit hold_req = 1'b0;

	i2c_master_register_access u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .action(action),
		.reg_address(reg_address), .write_data(write_data), .sda_in(sda_in),
		.out_valid(out_valid), .out_stall(out_stall), .scl_level(scl_level),
		.sda_level(sda_level), .busy_res(busy_res), .done_res(done_res),
		.read_data(read_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bus-level predictor: apply one accepted beat to the mirrored master and
	// return what the block must report for it.
	task automatic advance_bus(input bus_beat_t b, output result_t r);
		int s, o;
		seg_kind_t kind;
		byte_src_t src;
		logic [7:0] tx;
		logic fin;
		fin = 1'b0;
		kind = SEG_STOP;
		src = SRC_ADDR_W;
		o = 0;
		case (b.action)
			ACT_TICK: begin
				if (bus_busy) begin
					s = bus_step;
					// locate the tick: start, 28-tick groups of byte plus acknowledge,
					// then for a read a repeated start, address+R, receive, NACK, stop
					if (s < 4) begin
						kind = SEG_START;
						o = s;
					end else if ((!bus_is_read && s < 88) || (bus_is_read && s < 60)) begin
						o = (s - 4) % 28;
						src = byte_src_t'((s - 4) / 28);
						kind = (o < 24) ? SEG_BYTE : SEG_ACK;
						if (o >= 24) o -= 24;
					end else if (!bus_is_read) begin
						kind = SEG_STOP;
						o = s - 88;
					end else if (s < 64) begin
						kind = SEG_START;
						o = s - 60;
					end else if (s < 92) begin
						o = s - 64;
						src = SRC_ADDR_R;
						kind = (o < 24) ? SEG_BYTE : SEG_ACK;
						if (o >= 24) o -= 24;
					end else if (s < 117) begin
						kind = SEG_RECV;
						o = s - 92;
					end else if (s < 120) begin
						kind = SEG_NACK;
						o = s - 117;
					end else begin
						kind = SEG_STOP;
						o = s - 120;
					end

					// the device address is read live, not latched with the command
					case (src)
						SRC_ADDR_W: tx = {dev_addr, 1'b0};
						SRC_REG:    tx = bus_reg;
						SRC_DATA:   tx = bus_data;
						default:    tx = {dev_addr, 1'b1};
					endcase

					case (kind)
						SEG_START: begin
							if (o == 0) bus_sda = 1'b1;
							else if (o == 1) bus_scl = 1'b1;
							else if (o == 2) bus_sda = 1'b0;
							else bus_scl = 1'b0;
						end
						SEG_BYTE: begin
							if (o % 3 == 0) bus_sda = tx[7 - o / 3];
							else if (o % 3 == 1) bus_scl = 1'b1;
							else bus_scl = 1'b0;
						end
						SEG_ACK: begin
							// the acknowledge sample itself changes nothing
							if (o == 0) bus_sda = 1'b1;
							else if (o == 1) bus_scl = 1'b1;
							else if (o == 3) bus_scl = 1'b0;
						end
						SEG_RECV: begin
							if (o == 0) bus_sda = 1'b1;
							else if ((o - 1) % 3 == 0) bus_scl = 1'b1;
							else if ((o - 1) % 3 == 1) bus_rx[7 - (o - 1) / 3] = b.sda_in;
							else bus_scl = 1'b0;
						end
						SEG_NACK: begin
							if (o == 0) bus_sda = 1'b1;
							else if (o == 1) bus_scl = 1'b1;
							else bus_scl = 1'b0;
						end
						default: begin
							if (o == 0) bus_sda = 1'b0;
							else if (o == 1) bus_scl = 1'b1;
							else bus_sda = 1'b1;
						end
					endcase

					if (int'(bus_step) + 1 >= (bus_is_read ? READ_TICKS : WRITE_TICKS)) begin
						bus_step = '0;
						bus_busy = 1'b0;
						fin = 1'b1;
						if (bus_is_read) reads_done++;
						else writes_done++;
					end else begin
						bus_step = bus_step + 7'd1;
					end
				end
			end
			ACT_WRITE, ACT_READ: begin
				// a command while busy is dropped without a trace
				if (!bus_busy) begin
					bus_reg = b.reg_address;
					if (b.action == ACT_WRITE) bus_data = b.write_data;
					bus_is_read = (b.action == ACT_READ);
					bus_busy = 1'b1;
					bus_step = '0;
				end
			end
			default: ;
		endcase
		r = '{scl_level: bus_scl, sda_level: bus_sda, busy_res: bus_busy,
			done_res: fin, read_data: bus_rx};
	endtask

	// Offer one beat and hold it until accepted, then close the burst with a
	// random gap where one is due.
	task automatic send_beat(input logic [1:0] act, input logic [7:0] ra, input logic [7:0] wd,
			input logic sd, input bit pinned, input result_t want);
		int gap;
		typed_results.push_back('{pinned, want});
		@(negedge clk);
		in_valid = 1'b1;
		action = act;
		reg_address = ra;
		write_data = wd;
		sda_in = sd;
		do @(posedge clk); while (in_stall);
		beats_sent++;
		if (burst_left > 0) burst_left--;
		if (dense_left > 0) begin
			dense_left--;
		end else if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = $urandom_range(1, 24);
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drain the pipeline, then write the device address over APB.
	task automatic write_device_address(input logic [6:0] addr);
		@(negedge clk);
		in_valid = 1'b0;
		while (bus_results_due.size() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = REG_DEVICE_ADDRESS;
		pwdata = PDATA_W'(addr);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		dev_addr = addr;
		addr_writes++;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// Scoreboard: check outgoing beats against the oldest due result, then
	// predict the incoming beat. A result never leaves in the cycle of its input.
	always @(posedge clk) begin : scoreboard
		result_t want, pred;
		typed_result_t fixed;
		bus_beat_t b;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (bus_results_due.size() == 0) begin
					$error("result beat arrived with nothing due");
					errors++;
				end else begin
					want = bus_results_due.pop_front();
					if (scl_level !== want.scl_level) begin
						$error("scl_level: expected %0b, got %0b", want.scl_level, scl_level);
						errors++;
					end
					if (sda_level !== want.sda_level) begin
						$error("sda_level: expected %0b, got %0b", want.sda_level, sda_level);
						errors++;
					end
					if (busy_res !== want.busy_res) begin
						$error("busy_res: expected %0b, got %0b", want.busy_res, busy_res);
						errors++;
					end
					if (done_res !== want.done_res) begin
						$error("done_res: expected %0b, got %0b", want.done_res, done_res);
						errors++;
					end
					if (read_data !== want.read_data) begin
						$error("read_data: expected %02h, got %02h", want.read_data, read_data);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				b = '{action: action, reg_address: reg_address, write_data: write_data,
					sda_in: sda_in};
				advance_bus(b, pred);
				fixed = typed_results.pop_front();
				// typed rows stand in for the predictor's answer
				bus_results_due.push_back(fixed.pinned ? fixed.want : pred);
			end
			if (in_valid && in_stall) input_held++;
		end
	end

	// Receiver: stall on shifting patterns; on request hold off for a long
	// stretch so that the output queue fills and the input backs up.
	initial begin : receiver
		rx_mode_t mode;
		int mode_left, hold_left, period, phase;
		mode = RX_FREE;
		mode_left = 0;
		hold_left = 0;
		period = 3;
		phase = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall = 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					mode_left = $urandom_range(16, 120);
					period = $urandom_range(2, 5);
				end
				mode_left--;
				phase++;
				case (mode)
					RX_FREE:  out_stall = 1'b0;
					RX_LIGHT: out_stall = ($urandom_range(0, 3) == 0);
					RX_HEAVY: out_stall = ($urandom_range(0, 3) != 0);
					default:  out_stall = (phase % period == 0);
				endcase
			end
		end
	end

	// Watchdog: end a hung run.
	initial begin : watchdog
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin : stimulus
		stim_row_t directed_rows [DIRECTED_ROWS];
		int rand_start, ticks, k, waited;
		bit is_rd;
		logic [6:0] a;

		// Directed table. A write is 91 ticks and a read 123: the tick runs
		// between command and final tick are checked by the predictor.
		directed_rows = '{
			// tick while idle straight after reset, address at its low extreme
			'{1'b1, 7'h00, ACT_TICK,     8'h00, 8'h00, 1'b0, 1,   1'b1, R_IDLE},
			// reserved action while idle
			'{1'b0, 7'h00, ACT_RESERVED, 8'hFF, 8'hFF, 1'b1, 1,   1'b1, R_IDLE},
			// write command: the command beat itself moves no line
			'{1'b0, 7'h00, ACT_WRITE,    8'hFF, 8'h00, 1'b0, 1,   1'b1, R_CMD},
			// commands while busy are dropped
			'{1'b0, 7'h00, ACT_READ,     8'h00, 8'hFF, 1'b1, 1,   1'b1, R_CMD},
			'{1'b0, 7'h00, ACT_WRITE,    8'h00, 8'hFF, 1'b1, 1,   1'b1, R_CMD},
			'{1'b0, 7'h00, ACT_TICK,     8'h00, 8'h00, 1'b0, 45,  1'b0, R_NONE},
			// reserved action in the middle of a transaction
			'{1'b0, 7'h00, ACT_RESERVED, 8'h00, 8'h00, 1'b0, 1,   1'b0, R_NONE},
			'{1'b0, 7'h00, ACT_TICK,     8'h00, 8'h00, 1'b1, 45,  1'b0, R_NONE},
			// the 91st tick closes the stop condition
			'{1'b0, 7'h00, ACT_TICK,     8'h00, 8'h00, 1'b1, 1,   1'b1, R_DONE},
			'{1'b0, 7'h00, ACT_TICK,     8'h00, 8'h00, 1'b1, 1,   1'b1, R_IDLE},
			// full read at the high address extreme, slave sending all ones
			'{1'b1, 7'h7F, ACT_READ,     8'h00, 8'h00, 1'b1, 1,   1'b1, R_CMD},
			'{1'b0, 7'h7F, ACT_TICK,     8'h00, 8'h00, 1'b1, 122, 1'b0, R_NONE},
			'{1'b0, 7'h7F, ACT_TICK,     8'h00, 8'h00, 1'b1, 1,   1'b1, R_DONE_FF},
			// write with a mixed pattern, received byte is kept
			'{1'b0, 7'h7F, ACT_WRITE,    8'hA5, 8'h5A, 1'b0, 1,   1'b1, R_CMD_FF},
			'{1'b0, 7'h7F, ACT_TICK,     8'h00, 8'h00, 1'b0, 91,  1'b0, R_NONE},
			// read with the slave holding SDA low: byte clears bit by bit
			'{1'b1, 7'h2A, ACT_READ,     8'h5A, 8'hA5, 1'b0, 1,   1'b1, R_CMD_FF},
			'{1'b0, 7'h2A, ACT_TICK,     8'h00, 8'h00, 1'b0, 123, 1'b0, R_NONE},
			'{1'b0, 7'h2A, ACT_TICK,     8'h00, 8'h00, 1'b0, 1,   1'b1, R_IDLE}
		};

		// hold reset, then release it on a falling edge
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i]) begin
			if (directed_rows[i].set_addr) write_device_address(directed_rows[i].addr);
			repeat (directed_rows[i].reps)
				send_beat(directed_rows[i].act, directed_rows[i].ra, directed_rows[i].wd,
					directed_rows[i].sd, directed_rows[i].pinned, directed_rows[i].want);
		end

		// Random stretch. Open with the long receiver hold-off while the sender
		// keeps offering back to back; no address write drains the queue meanwhile.
		hold_req = 1'b1;
		dense_left = 48;
		rand_start = beats_sent;
		while (beats_sent - rand_start < RANDOM_BEATS) begin
			if (dense_left == 0 && $urandom_range(0, 2) == 0) begin
				case ($urandom_range(0, 3))
					0:       a = 7'h00;
					1:       a = 7'h7F;
					default: a = 7'($urandom);
				endcase
				write_device_address(a);
			end
			is_rd = 1'($urandom);
			ticks = is_rd ? READ_TICKS : WRITE_TICKS;
			// cut some sequences short so the next command lands while busy
			if ($urandom_range(0, 5) == 0) ticks = $urandom_range(1, ticks - 1);
			send_beat(is_rd ? ACT_READ : ACT_WRITE, 8'($urandom), 8'($urandom),
				1'($urandom), 1'b0, R_NONE);
			for (k = 0; k < ticks; k++) begin
				case ($urandom_range(0, 199))
					0, 1, 2, 3:
						send_beat(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
							1'($urandom), 1'b0, R_NONE);
					4:
						// change the address mid-transaction: it is picked up live
						if (dense_left == 0) write_device_address(7'($urandom));
					default: ;
				endcase
				send_beat(ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, R_NONE);
			end
			repeat ($urandom_range(0, 3))
				send_beat(ACT_TICK, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0, R_NONE);
		end

		// drop valid and wait for the last results, with a limit
		@(negedge clk);
		in_valid = 1'b0;
		waited = 0;
		while (bus_results_due.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (bus_results_due.size() != 0) begin
			$error("%0d result beats never arrived", bus_results_due.size());
			errors++;
		end

		$display("run covered %0d beats: %0d writes and %0d reads completed, %0d address writes",
			beats_sent, writes_done, reads_done, addr_writes);
		$display("input held off for %0d cycles under receiver back-pressure", input_held);
		if (errors == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
